### hdl/tptb_pkg.sv
package tptb_pkg;

	localparam int PULSE_W = 32;
	localparam int DIV_W = 24;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 72;

	localparam int SHORT_STEPS = 8;
	localparam int LONG_STEPS = 24;
	localparam int STEP_W = $clog2(LONG_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_DIV = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_DIV = CFG_IDX_W'(1);

	localparam logic [DIV_W-1:0] SHORT_DIV_RST = DIV_W'(532137);
	localparam logic [DIV_W-1:0] LONG_DIV_RST = DIV_W'(66517);
	localparam logic [DIV_W-1:0] LONG_SAT = {DIV_W{1'b1}};

	// one classified pulse waiting for the back end
	typedef struct packed {
		logic [PULSE_W-1:0] pulse;
		logic [CNT_W-1:0] elapsed;
		logic is_long;
		logic sat;
	} entry_t;

	// request to the serial divider
	typedef struct packed {
		logic start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0] rem_init;
		logic [DIV_W-1:0] num_low;
		logic [DIV_W-1:0] div;
	} div_req_t;

endpackage

### hdl/tape_pulse_to_tap_bytes.sv
// Encodes each pulse beat (length in microseconds) as TAP v1 bytes: one byte
// when floor(pulse*65536/short_divisor) is below 256, otherwise a zero byte and
// the 24-bit long quotient (saturated) least significant byte first. The front
// stage registers an accepted pulse and classifies it by compare; a queue of
// QUEUE_DEPTH entries feeds the back end, whose serial divider makes one
// quotient bit per cycle. For each entry the back end sets up the divider,
// runs 8 or 24 divide steps, takes the quotient, then emits one output beat
// per cycle while the output is ready; a saturated long code skips the divider.
// An accepted pulse passes the front register, the queue, the divider (unless
// saturated) and the output register before its first output beat is valid.
// Pulses queue up while the back end and the output register drain, so output
// stalls do not block input until the queue is full.
module tape_pulse_to_tap_bytes import tptb_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [DIV_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [PULSE_W-1:0] s_tdata, // [31:0] pulse_us
	output logic m_tvalid,
	input logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata, // [7:0] data_byte, [39:8] bytes_so_far,
	// [71:40] elapsed_us
	output logic m_tlast // last_byte
);

	logic [DIV_W-1:0] short_div_q;
	logic [DIV_W-1:0] long_div_q;
	logic push;
	entry_t push_entry;
	logic q_full;
	logic q_valid;
	logic q_pop;
	entry_t q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_div_q <= SHORT_DIV_RST;
			long_div_q <= LONG_DIV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_DIV: short_div_q <= cfg_data;
				REG_LONG_DIV: long_div_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tptb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.short_div(short_div_q),
		.long_div(long_div_q),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	tptb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_entry),
		.pop(q_pop),
		.pop_data(q_entry),
		.full(q_full),
		.not_empty(q_valid)
	);

	tptb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop),
		.short_div(short_div_q),
		.long_div(long_div_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

### hdl/tptb_fifo.sv
module tptb_fifo import tptb_pkg::*; #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_data,
	input logic pop,
	output entry_t pop_data,
	output logic full,
	output logic not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/tptb_front.sv
module tptb_front import tptb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [PULSE_W-1:0] s_tdata, // pulse_us
	input logic [DIV_W-1:0] short_div,
	input logic [DIV_W-1:0] long_div,
	input logic q_full,
	output logic push,
	output entry_t push_entry
);

	logic valid_s1;
	entry_t entry_s1;
	logic [CNT_W-1:0] time_q;
	logic [CNT_W-1:0] time_next;
	logic accept;

	assign s_tready = !valid_s1 || !q_full;
	assign accept = s_tvalid && s_tready;
	assign push = valid_s1;
	assign push_entry = entry_s1;
	assign time_next = time_q + CNT_W'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			entry_s1 <= '0;
			time_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				time_q <= time_next;
				entry_s1.pulse <= s_tdata;
				entry_s1.elapsed <= time_next;
				// short quotient >= 256 iff pulse*256 >= short divisor
				entry_s1.is_long <= {s_tdata, 8'h00} >= {16'h0000, short_div};
				// long quotient overflows 24 bits iff pulse >= long divisor * 256
				entry_s1.sat <= s_tdata >= {long_div, 8'h00};
			end else if (!q_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

### hdl/tptb_div.sv
module tptb_div import tptb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic done,
	output logic [DIV_W-1:0] quot
);

	logic run_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] quot_q;
	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign ge = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			div_q <= '0;
			quot_q <= '0;
		end else begin
			if (req.start) begin
				run_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q <= req.steps;
				rem_q <= req.rem_init;
				num_q <= req.num_low;
				div_q <= req.div;
				quot_q <= '0;
			end else if (run_q) begin
				rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				num_q <= {num_q[DIV_W-2:0], 1'b0};
				quot_q <= {quot_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
				if (cnt_q == STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/tptb_back.sv
module tptb_back import tptb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input entry_t q_entry,
	output logic q_pop,
	input logic [DIV_W-1:0] short_div,
	input logic [DIV_W-1:0] long_div,
	output logic m_tvalid,
	input logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata, // data_byte, bytes_so_far, elapsed_us
	output logic m_tlast // last_byte
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	state_t state_q;
	entry_t ent_q;
	logic [DIV_W-1:0] lv_q;
	logic [1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic m_tvalid_q;
	logic m_tlast_q;
	logic [7:0] byte_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic [CNT_W-1:0] elap_out_q;
	div_req_t req;
	logic div_done;
	logic [DIV_W-1:0] div_quot;
	logic [7:0] sel_byte;
	logic sel_last;
	logic slot_free;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		req.start = q_pop && !(q_entry.is_long && q_entry.sat);
		if (q_entry.is_long) begin
			req.steps = STEP_W'(LONG_STEPS);
			req.rem_init = q_entry.pulse[PULSE_W-1:8];
			req.num_low = {q_entry.pulse[7:0], 16'h0000};
			req.div = long_div;
		end else begin
			req.steps = STEP_W'(SHORT_STEPS);
			req.rem_init = {q_entry.pulse[15:0], 8'h00};
			req.num_low = '0;
			req.div = short_div;
		end
	end

	tptb_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.done(div_done),
		.quot(div_quot)
	);

	always_comb begin
		sel_byte = lv_q[7:0];
		sel_last = 1'b1;
		if (ent_q.is_long) begin
			case (idx_q)
				2'd0: begin
					sel_byte = 8'h00;
					sel_last = 1'b0;
				end
				2'd1: begin
					sel_byte = lv_q[7:0];
					sel_last = 1'b0;
				end
				2'd2: begin
					sel_byte = lv_q[15:8];
					sel_last = 1'b0;
				end
				default: begin
					sel_byte = lv_q[23:16];
					sel_last = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= '0;
			lv_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			byte_q <= '0;
			cnt_out_q <= '0;
			elap_out_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						ent_q <= q_entry;
						idx_q <= '0;
						if (q_entry.is_long && q_entry.sat) begin
							lv_q <= LONG_SAT;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						lv_q <= div_quot;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q <= sel_last;
						byte_q <= sel_byte;
						count_q <= count_q + 1'b1;
						cnt_out_q <= count_q + 1'b1;
						elap_out_q <= ent_q.elapsed;
						if (sel_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tdata = {elap_out_q, cnt_out_q, byte_q};

endmodule

### hdl/tptb_chk.sv
module tptb_chk import tptb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic m_tlast
);

	logic beat;
	logic prev_last_q;
	logic [CNT_W-1:0] prev_count_q;
	logic [CNT_W-1:0] prev_elap_q;

	assign beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
			prev_count_q <= '0;
			prev_elap_q <= '0;
		end else if (beat) begin
			prev_last_q <= m_tlast;
			prev_count_q <= m_tdata[39:8];
			prev_elap_q <= m_tdata[71:40];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		beat |-> m_tdata[39:8] == prev_count_q + 1'b1)
		else $error("byte count skipped");

	a_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !prev_last_q |-> m_tdata[71:40] == prev_elap_q)
		else $error("elapsed time changed inside one pulse");

	a_long_head: assert property (@(posedge clk) disable iff (!arst_n)
		beat && prev_last_q && !m_tlast |-> m_tdata[7:0] == 8'h00)
		else $error("long code does not open with a zero byte");

endmodule

bind tape_pulse_to_tap_bytes tptb_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
